// ===== rtl/core/srpm_pkg.sv =====
// ----------------------------------------------------------------------------
// srpm_pkg
// Types and constants shared by the step response phase monitor.
// ----------------------------------------------------------------------------
package srpm_pkg;

  // Phase codes as they appear on the result channel.
  localparam logic [2:0] PH_REST      = 3'd0;
  localparam logic [2:0] PH_TRANSIENT = 3'd1;
  localparam logic [2:0] PH_RISE      = 3'd2;
  localparam logic [2:0] PH_OVERSHOOT = 3'd3;
  localparam logic [2:0] PH_BOUNDED   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ERROR_BAND          = 3'd0;
  localparam logic [2:0] CFG_OVERSHOOT_GAIN      = 3'd1;
  localparam logic [2:0] CFG_RISE_ERROR_LEVEL    = 3'd2;
  localparam logic [2:0] CFG_RISE_DEADLINE       = 3'd3;
  localparam logic [2:0] CFG_SETTLE_DEADLINE     = 3'd4;
  localparam logic [2:0] CFG_SETTLE_COUNT_NEEDED = 3'd5;

  localparam int unsigned SETTLE_DIV = 30;
  localparam int unsigned QUO_W      = 28;  // 0xFFFFFFFF / 30 fits in 28 bits
  localparam int unsigned REM_W      = 5;

  typedef struct packed {
    logic signed [31:0] ref_value;
    logic signed [31:0] err_value;
    logic signed [31:0] plant_output;
    logic signed [31:0] sample_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       seen_transient;
    logic       seen_rise;
    logic       seen_overshoot;
    logic       seen_bounded;
    logic       seen_rest_return;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] error_band;
    logic signed [31:0] overshoot_gain;
    logic signed [31:0] rise_error_level;
    logic signed [31:0] rise_deadline;
    logic signed [31:0] settle_deadline;
    logic        [31:0] settle_count_needed;
  } cfg_t;

  // A sample after classification: the guards that do not depend on state.
  typedef struct packed {
    logic               settled;   // err <= error band
    logic               over;      // output above gain * reference
    logic               rise_ok;   // rise level and rise deadline both met
    logic               start;     // reference set and err >= error band
    logic signed [31:0] sample_time;
  } class_t;

endpackage

// ===== rtl/core/step_response_phase_monitor.sv =====
// ----------------------------------------------------------------------------
// step_response_phase_monitor
// Classifies a control loop's step response one sample at a time.
// ----------------------------------------------------------------------------
// Samples (reference, error, plant output, time stamp) enter on the in_
// valid/ready channel; every sample yields exactly one result on the out_
// channel: the new phase and the five sticky visited flags.
// A sample accepted on the in_ channel has its 64-bit overshoot threshold
// registered from the single 32x32 multiplier, is then written into the
// queue, and is then taken by the phase state machine, which writes the
// result register. One sample per cycle is sustained while the receiver
// does not stall; the phase update, including the saturating settle counter
// and its running quotient by 30, is computed combinationally and is
// registered together with the result.
// When the receiver stalls, the result register holds, the phase machine
// stops, and the queue of QUEUE_DEPTH classified samples fills before
// in_ready drops; the front keeps accepting until then.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata by
// the user only while the block is idle (not enforced); other indexes are ignored.
// Synchronous reset returns phase to rest, clears flags and counter, and
// loads the register defaults (overshoot gain 1, all others 0).
// ----------------------------------------------------------------------------
module step_response_phase_monitor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  srpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output srpm_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import srpm_pkg::*;

  cfg_t   cfg_r;
  logic   push;
  class_t push_data;
  logic   q_full;
  logic   pop;
  logic   q_not_empty;
  class_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.error_band          <= 32'sd0;
      cfg_r.overshoot_gain      <= 32'sd1;
      cfg_r.rise_error_level    <= 32'sd0;
      cfg_r.rise_deadline       <= 32'sd0;
      cfg_r.settle_deadline     <= 32'sd0;
      cfg_r.settle_count_needed <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ERROR_BAND:          cfg_r.error_band          <= $signed(cfg_wdata);
        CFG_OVERSHOOT_GAIN:      cfg_r.overshoot_gain      <= $signed(cfg_wdata);
        CFG_RISE_ERROR_LEVEL:    cfg_r.rise_error_level    <= $signed(cfg_wdata);
        CFG_RISE_DEADLINE:       cfg_r.rise_deadline       <= $signed(cfg_wdata);
        CFG_SETTLE_DEADLINE:     cfg_r.settle_deadline     <= $signed(cfg_wdata);
        CFG_SETTLE_COUNT_NEEDED: cfg_r.settle_count_needed <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  srpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  srpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  srpm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/core/srpm_front.sv =====
// ----------------------------------------------------------------------------
// srpm_front
// Accepts samples, forms the overshoot threshold and evaluates the
// state-independent guards, then hands the classified sample to the queue.
// ----------------------------------------------------------------------------
module srpm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  srpm_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  srpm_pkg::in_item_t in_data,
  output logic              push,
  output srpm_pkg::class_t  push_data,
  input  logic              q_full
);
  import srpm_pkg::*;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic signed [63:0] thr_r;
  logic signed [31:0] sys_r;
  logic               settled_r;
  logic               rise_ok_r;
  logic               start_r;
  logic signed [31:0] tim_r;
  logic               accept;
  logic signed [63:0] sys_ext;

  assign push     = s1_valid_r && !q_full;
  assign in_ready = !s1_valid_r || push;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      thr_r     <= 64'(cfg.overshoot_gain) * 64'(in_data.ref_value);
      sys_r     <= in_data.plant_output;
      settled_r <= in_data.err_value <= cfg.error_band;
      rise_ok_r <= (in_data.err_value <= cfg.rise_error_level) &&
                   (in_data.sample_time <= cfg.rise_deadline);
      start_r   <= (in_data.ref_value != 32'sd0) &&
                   (in_data.err_value >= cfg.error_band);
      tim_r     <= in_data.sample_time;
    end
  end

  // The product is exact at 64 bits, so the compare never wraps.
  assign sys_ext = 64'(sys_r);

  always_comb begin
    push_data.settled     = settled_r;
    push_data.over        = sys_ext > thr_r;
    push_data.rise_ok     = rise_ok_r;
    push_data.start       = start_r;
    push_data.sample_time = tim_r;
  end

endmodule

// ===== rtl/core/srpm_queue.sv =====
// ----------------------------------------------------------------------------
// srpm_queue
// Short first-in first-out queue of classified samples between the front
// and back parts.
// ----------------------------------------------------------------------------
module srpm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srpm_pkg::class_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output srpm_pkg::class_t pop_data
);
  import srpm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  class_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/srpm_back.sv =====
// ----------------------------------------------------------------------------
// srpm_back
// Phase state machine: takes classified samples from the queue, updates
// phase, visited flags and settle counter, and holds the result register.
// ----------------------------------------------------------------------------
module srpm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  srpm_pkg::cfg_t    cfg,
  input  logic              q_not_empty,
  input  srpm_pkg::class_t  q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output srpm_pkg::out_item_t out_data
);
  import srpm_pkg::*;

  typedef enum logic [2:0] {
    S_REST      = PH_REST,
    S_TRANSIENT = PH_TRANSIENT,
    S_RISE      = PH_RISE,
    S_OVERSHOOT = PH_OVERSHOOT,
    S_BOUNDED   = PH_BOUNDED
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         flags_r, flags_nxt;   // transient, rise, overshoot, bounded, rest return
  logic [31:0]        cnt_r, cnt_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;       // cnt_r / 30
  logic [REM_W-1:0]   rem_r, rem_nxt;       // cnt_r % 30
  logic               pend_r, pend_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          result;

  logic [31:0]        cnt_eff;
  logic [QUO_W-1:0]   quo_eff;
  logic [REM_W-1:0]   rem_eff;
  logic signed [32:0] adj;
  logic               adj_ok;

  assign pop       = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A pending clear zeroes the counter before it is used in bounded.
  assign cnt_eff = pend_r ? '0 : cnt_r;
  assign quo_eff = pend_r ? '0 : quo_r;
  assign rem_eff = pend_r ? '0 : rem_r;
  assign adj     = 33'(q_data.sample_time) - $signed({5'd0, quo_eff});
  assign adj_ok  = adj <= 33'(cfg.settle_deadline);

  always_comb begin
    state_nxt = state_r;
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      S_REST: begin
        if (q_data.start) begin
          state_nxt = S_TRANSIENT;
        end
      end
      S_TRANSIENT: begin
        flags_nxt[0] = 1'b1;
        if (q_data.rise_ok && !flags_r[1]) begin
          state_nxt = S_RISE;
        end else if (q_data.settled) begin
          state_nxt = S_BOUNDED;
        end else if (q_data.over) begin
          state_nxt = S_OVERSHOOT;
        end
      end
      S_RISE: begin
        flags_nxt[1] = 1'b1;
        if (q_data.over) begin
          state_nxt = S_OVERSHOOT;
        end else if (q_data.settled) begin
          state_nxt = S_BOUNDED;
        end
      end
      S_OVERSHOOT: begin
        flags_nxt[2] = 1'b1;
        if (q_data.settled) begin
          state_nxt = S_BOUNDED;
        end else if (!q_data.over) begin
          state_nxt = S_TRANSIENT;
        end
      end
      S_BOUNDED: begin
        flags_nxt[3] = 1'b1;
        cnt_nxt      = cnt_eff;
        quo_nxt      = quo_eff;
        rem_nxt      = rem_eff;
        if (q_data.settled && adj_ok && (cnt_eff >= cfg.settle_count_needed)) begin
          state_nxt    = S_REST;
          pend_nxt     = 1'b1;
          flags_nxt[4] = 1'b1;
        end else if (!q_data.settled) begin
          state_nxt = q_data.over ? S_OVERSHOOT : S_TRANSIENT;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          // Quotient and remainder by 30 track the counter as it counts up.
          if (cnt_eff != '1) begin
            cnt_nxt = cnt_eff + 32'd1;
            if (rem_eff == REM_W'(SETTLE_DIV - 1)) begin
              rem_nxt = '0;
              quo_nxt = quo_eff + QUO_W'(1);
            end else begin
              rem_nxt = rem_eff + REM_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_REST;
      end
    endcase
  end

  always_comb begin
    result.phase            = state_nxt;
    result.seen_transient   = flags_nxt[0];
    result.seen_rise        = flags_nxt[1];
    result.seen_overshoot   = flags_nxt[2];
    result.seen_bounded     = flags_nxt[3];
    result.seen_rest_return = flags_nxt[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_REST;
      flags_r     <= '0;
      cnt_r       <= '0;
      quo_r       <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      if (pop) begin
        state_r     <= state_nxt;
        flags_r     <= flags_nxt;
        cnt_r       <= cnt_nxt;
        quo_r       <= quo_nxt;
        rem_r       <= rem_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/srpm_checker.sv =====
// ----------------------------------------------------------------------------
// srpm_checker
// Port-level checks on the step response phase monitor, bound to the top.
// ----------------------------------------------------------------------------
module srpm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input srpm_pkg::out_item_t out_data
);
  import srpm_pkg::*;

  // No result is shown right after reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A return to rest can only come from bounded, which marks itself.
  a_rest_ret_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.seen_rest_return |-> out_data.seen_bounded)
    else $error("rest return without bounded");

  // Rise is entered only from transient.
  a_rise_after_trans: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase == PH_RISE) |-> out_data.seen_transient)
    else $error("rise without transient");

  // Bounded is entered only from a phase that marks itself.
  a_bounded_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.phase == PH_BOUNDED) |->
      (out_data.seen_transient || out_data.seen_rise || out_data.seen_overshoot))
    else $error("bounded without earlier phase");

endmodule

bind step_response_phase_monitor srpm_checker u_srpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
